FILE: src/gha_pkg.sv
// shared constants, codes and types of the generational handle allocator
package gha_pkg;

	// table sizes
	localparam int NUM_CLIENTS      = 4;
	localparam int SLOTS_PER_CLIENT = 8;
	localparam int MAX_ROWS         = 64;
	localparam int MAX_COLS         = 128;
	localparam int ARENA_CELLS      = 16384;
	localparam int MAX_RESULTS      = 33;
	localparam int TOTAL_SLOTS      = NUM_CLIENTS * SLOTS_PER_CLIENT;

	// field widths
	localparam int IDX_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int CL_W   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int GEN_W  = 16;
	localparam int ROW_W  = 7;
	localparam int COL_W  = 8;
	localparam int OFF_W  = 15;
	localparam int CNT_W  = 14;
	localparam int SUM_W  = OFF_W + 1;
	localparam int MV_W   = $clog2(MAX_RESULTS);
	localparam int MV_MAX = MAX_RESULTS - 1;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_QUERY   = 2'd2,
		OP_RELEASE = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_BAD_HANDLE = 2'd1,
		STAT_NO_ROOM    = 2'd2
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_REL_RD,
		S_REL_EV,
		S_REL_END
	} state_e_t;

	// one slot record as kept in the slot memory
	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [ROW_W-1:0] rows;
		logic [COL_W-1:0] cols;
		logic [OFF_W-1:0] offset;
		logic [CNT_W-1:0] length;
	} slot_rec_t;

	// access to the slot memory
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		slot_rec_t        wr_data;
	} mem_req_t;

	// one result item
	typedef struct packed {
		logic [1:0]       status;
		logic [31:0]      new_handle;
		logic [ROW_W-1:0] tile_rows;
		logic [COL_W-1:0] tile_cols;
		logic [OFF_W-1:0] cell_offset;
		logic [CNT_W-1:0] cell_count;
		logic [OFF_W-1:0] move_source;
		logic             is_move;
		logic             last;
	} result_t;

	// slots that belong to one client
	function automatic logic [TOTAL_SLOTS-1:0] client_mask(input logic [CL_W-1:0] c);
		logic [TOTAL_SLOTS-1:0] m;
		int                     lo;
		lo = int'(c) * SLOTS_PER_CLIENT;
		m  = '0;
		for (int i = 0; i < TOTAL_SLOTS; i++) begin
			m[i] = (i >= lo) && (i < lo + SLOTS_PER_CLIENT);
		end
		return m;
	endfunction

endpackage

FILE: src/gha_slot_mem.sv
// slot record memory: one write port, one registered read port
module gha_slot_mem (
	input  logic              clk,
	input  gha_pkg::mem_req_t req,
	output gha_pkg::slot_rec_t rd_data
);
	import gha_pkg::*;

	slot_rec_t mem_q [TOTAL_SLOTS];

	// write and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr];
		end
	end

endmodule

FILE: src/gha_out_reg.sv
// output register holding one result item until the receiver takes it
module gha_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  gha_pkg::result_t  res,
	input  logic              out_ready,
	output logic              out_valid,
	output gha_pkg::result_t  res_q,
	output logic              free
);
	import gha_pkg::*;

	logic valid_q;

	assign out_valid = valid_q;
	assign free      = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

FILE: src/gha_ctrl.sv
// sequencer: slot bits, arena fill, handle checks and the release walk
module gha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [7:0]         client,
	input  logic [31:0]        handle,
	input  logic [15:0]        req_rows,
	input  logic [15:0]        req_cols,
	output gha_pkg::mem_req_t  mem_req,
	input  gha_pkg::slot_rec_t rd_data,
	input  logic               out_free,
	output logic               out_load,
	output gha_pkg::result_t   out_res
);
	import gha_pkg::*;

	state_e_t state_q, state_d;

	logic [TOTAL_SLOTS-1:0] in_use_q, in_use_d;
	logic [TOTAL_SLOTS-1:0] written_q, written_d;
	logic [OFF_W-1:0]       fill_q, fill_d;
	logic [IDX_W-1:0]       walk_q, walk_d;
	logic [OFF_W-1:0]       acc_q, acc_d;
	logic [MV_W-1:0]        mv_cnt_q, mv_cnt_d;

	// captured item
	op_e_t            op_q;
	logic             client_ok_q;
	logic [7:0]       client_q;
	logic [31:0]      handle_q;
	logic [ROW_W-1:0] rows_q;
	logic [COL_W-1:0] cols_q;
	logic             size_ok_q;
	logic [CNT_W-1:0] need_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       slot_q;
	logic             found_q;

	// decode at the input
	logic                   accept;
	logic                   client_ok;
	logic [CL_W-1:0]        cl_idx;
	logic                   size_ok;
	logic [ROW_W+COL_W-1:0] prod;
	logic [7:0]             free_slot;
	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic [IDX_W-1:0]       hdl_idx;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign client_ok = ({1'b0, client} < 9'(NUM_CLIENTS));
	assign cl_idx    = client_ok ? CL_W'(client) : '0;
	assign size_ok   = (req_rows != '0) && (req_cols != '0) &&
		(req_rows <= 16'(MAX_ROWS)) && (req_cols <= 16'(MAX_COLS));
	assign prod      = {{COL_W{1'b0}}, req_rows[ROW_W-1:0]} *
		{{ROW_W{1'b0}}, req_cols[COL_W-1:0]};
	assign free_idx  = IDX_W'(int'(cl_idx) * SLOTS_PER_CLIENT + int'(free_slot));
	assign hdl_idx   = IDX_W'(int'(cl_idx) * SLOTS_PER_CLIENT + int'(handle[7:0]));

	// lowest free slot of the client
	always_comb begin
		free_slot  = '0;
		free_found = 1'b0;
		for (int s = SLOTS_PER_CLIENT - 1; s >= 0; s--) begin
			if (!in_use_q[IDX_W'(int'(cl_idx) * SLOTS_PER_CLIENT + s)]) begin
				free_slot  = 8'(s);
				free_found = 1'b1;
			end
		end
	end

	// checks in the execute cycle
	logic [SUM_W-1:0] fill_sum;
	logic             room_ok;
	logic             handle_ok;
	logic [GEN_W-1:0] gen_old;
	logic [GEN_W-1:0] gen_inc;
	logic [GEN_W-1:0] gen_new;
	logic             walk_live;
	logic             walk_move;
	logic             walk_emit;

	assign fill_sum  = SUM_W'(fill_q) + SUM_W'(need_q);
	assign room_ok   = (fill_sum <= SUM_W'(ARENA_CELLS));
	assign handle_ok = (handle_q[15:8] == client_q) &&
		(handle_q[7:0] < 8'(SLOTS_PER_CLIENT)) && in_use_q[idx_q] &&
		(rd_data.gen == handle_q[31:16]);
	assign gen_old   = written_q[idx_q] ? rd_data.gen : '0;
	assign gen_inc   = gen_old + 1'b1;
	assign gen_new   = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
	assign walk_live = in_use_q[walk_q];
	assign walk_move = walk_live && (rd_data.offset != acc_q);
	assign walk_emit = walk_move && (mv_cnt_q < MV_W'(MV_MAX));

	// next state, memory access and result
	always_comb begin
		state_d   = state_q;
		in_use_d  = in_use_q;
		written_d = written_q;
		fill_d    = fill_q;
		walk_d    = walk_q;
		acc_d     = acc_q;
		mv_cnt_d  = mv_cnt_q;
		mem_req   = '0;
		out_load  = 1'b0;
		out_res   = '0;
		out_res.last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = (op_e_t'(operation) == OP_CREATE) ? free_idx : hdl_idx;
					if (op_e_t'(operation) == OP_RELEASE && client_ok) begin
						in_use_d = in_use_q & ~client_mask(cl_idx);
						walk_d   = '0;
						acc_d    = '0;
						mv_cnt_d = '0;
						state_d  = S_REL_RD;
					end else begin
						state_d  = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					if (!client_ok_q) begin
						out_res.status = STAT_BAD_HANDLE;
					end else begin
						case (op_q)
							OP_CREATE: begin
								if (!size_ok_q || !room_ok || !found_q) begin
									out_res.status = STAT_NO_ROOM;
								end else begin
									mem_req.wr_en          = 1'b1;
									mem_req.wr_addr        = idx_q;
									mem_req.wr_data.gen    = gen_new;
									mem_req.wr_data.rows   = rows_q;
									mem_req.wr_data.cols   = cols_q;
									mem_req.wr_data.offset = fill_q;
									mem_req.wr_data.length = need_q;
									in_use_d[idx_q]        = 1'b1;
									written_d[idx_q]       = 1'b1;
									fill_d                 = OFF_W'(fill_sum);
									out_res.status         = STAT_OK;
									out_res.new_handle     = {gen_new, client_q, slot_q};
									out_res.tile_rows      = rows_q;
									out_res.tile_cols      = cols_q;
									out_res.cell_offset    = fill_q;
									out_res.cell_count     = need_q;
								end
							end
							OP_DESTROY: begin
								if (handle_ok) begin
									in_use_d[idx_q] = 1'b0;
									out_res.status  = STAT_OK;
								end else begin
									out_res.status  = STAT_BAD_HANDLE;
								end
							end
							OP_QUERY: begin
								if (handle_ok) begin
									out_res.status      = STAT_OK;
									out_res.tile_rows   = rd_data.rows;
									out_res.tile_cols   = rd_data.cols;
									out_res.cell_offset = rd_data.offset;
									out_res.cell_count  = rd_data.length;
								end else begin
									out_res.status      = STAT_BAD_HANDLE;
								end
							end
							default: begin
								// release of an in-range client never comes here
								out_res.status = STAT_BAD_HANDLE;
							end
						endcase
					end
				end
			end
			S_REL_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = walk_q;
				state_d         = S_REL_EV;
			end
			S_REL_EV: begin
				// a move that is reported waits for room in the output register
				if (!walk_emit || out_free) begin
					if (walk_move) begin
						mem_req.wr_en          = 1'b1;
						mem_req.wr_addr        = walk_q;
						mem_req.wr_data        = rd_data;
						mem_req.wr_data.offset = acc_q;
						if (walk_emit) begin
							mv_cnt_d = mv_cnt_q + 1'b1;
						end
					end
					if (walk_emit) begin
						out_load            = 1'b1;
						out_res.status      = STAT_OK;
						out_res.cell_offset = acc_q;
						out_res.cell_count  = rd_data.length;
						out_res.move_source = rd_data.offset;
						out_res.is_move     = 1'b1;
						out_res.last        = 1'b0;
					end
					if (walk_live) begin
						acc_d = acc_q + OFF_W'(rd_data.length);
					end
					if (walk_q == IDX_W'(TOTAL_SLOTS - 1)) begin
						state_d = S_REL_END;
					end else begin
						walk_d  = walk_q + 1'b1;
						state_d = S_REL_RD;
					end
				end
			end
			S_REL_END: begin
				if (out_free) begin
					out_load            = 1'b1;
					out_res.status      = STAT_OK;
					out_res.cell_offset = acc_q;
					fill_d              = acc_q;
					state_d             = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_use_q  <= '0;
			written_q <= '0;
			fill_q    <= '0;
			walk_q    <= '0;
			acc_q     <= '0;
			mv_cnt_q  <= '0;
		end else begin
			state_q   <= state_d;
			in_use_q  <= in_use_d;
			written_q <= written_d;
			fill_q    <= fill_d;
			walk_q    <= walk_d;
			acc_q     <= acc_d;
			mv_cnt_q  <= mv_cnt_d;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op_e_t'(operation);
			client_ok_q <= client_ok;
			client_q    <= client;
			handle_q    <= handle;
			rows_q      <= req_rows[ROW_W-1:0];
			cols_q      <= req_cols[COL_W-1:0];
			size_ok_q   <= size_ok;
			need_q      <= CNT_W'(prod);
			idx_q       <= (op_e_t'(operation) == OP_CREATE) ? free_idx : hdl_idx;
			slot_q      <= free_slot;
			found_q     <= free_found;
		end
	end

	// fill level never passes the arena size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= OFF_W'(ARENA_CELLS))
		else $error("arena fill beyond arena size");

	// a result never overwrites one that is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded into a full output register");

	// release clears every slot of the client before the walk
	a_rel_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_e_t'(operation) == OP_RELEASE && client_ok) |=>
		((in_use_q & client_mask($past(cl_idx))) == '0))
		else $error("released client still holds a slot");

	// the memory is written only while an item is being executed or walked
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (state_q == S_EXEC || state_q == S_REL_EV))
		else $error("slot memory written outside execute or walk");

endmodule

FILE: src/generational_handle_allocator_top.sv
// Generational handle allocator: per-client tile slots over a bump-allocated cell arena.
//
// Input channel in_valid/in_ready carries one item: operation (create, destroy,
// query, release), client, handle, req_rows, req_cols. Output channel
// out_valid/out_ready carries result items; last marks the final one of an item.
// Create, destroy and query give one result; release gives one move item per
// survivor tile that shifts down, then one item with the new fill level.
// Handles are generation[31:16], client[15:8], slot[7:0].
// Create, destroy, query: the item is captured, checked in the execute state against
// the registered slot read, and its result is loaded into the output register; no new
// item is taken until that result is loaded.
// Release: each of the 32 table slots is read, then evaluated, and one final
// item with the new fill level follows.
// Reset clears all in-use and written bits, so old generations count as zero, and
// the fill level at once; no clearing pass is needed. A stalled receiver holds the
// result in the output register; one further item may be taken meanwhile, and a
// release walk pauses on each move until the register frees.
module generational_handle_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  client,
	input  logic [31:0] handle,
	input  logic [15:0] req_rows,
	input  logic [15:0] req_cols,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] new_handle,
	output logic [6:0]  tile_rows,
	output logic [7:0]  tile_cols,
	output logic [14:0] cell_offset,
	output logic [13:0] cell_count,
	output logic [14:0] move_source,
	output logic        is_move,
	output logic        last
);
	import gha_pkg::*;

	mem_req_t  mem_req;
	slot_rec_t rd_data;
	logic      out_free;
	logic      out_load;
	result_t   out_res;
	result_t   res_q;

	// slot record store
	gha_slot_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// sequencer
	gha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.client    (client),
		.handle    (handle),
		.req_rows  (req_rows),
		.req_cols  (req_cols),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.out_free  (out_free),
		.out_load  (out_load),
		.out_res   (out_res)
	);

	// result register
	gha_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.res       (out_res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q),
		.free      (out_free)
	);

	// result fields to ports
	assign status      = res_q.status;
	assign new_handle  = res_q.new_handle;
	assign tile_rows   = res_q.tile_rows;
	assign tile_cols   = res_q.tile_cols;
	assign cell_offset = res_q.cell_offset;
	assign cell_count  = res_q.cell_count;
	assign move_source = res_q.move_source;
	assign is_move     = res_q.is_move;
	assign last        = res_q.last;

endmodule
